@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

   localparam int unsigned DivSteps = 32;

   localparam logic [31:0] PresOffset   = 32'd64000;
   localparam logic [31:0] PresFullSc   = 32'd1048576;
   localparam logic [31:0] PresScale    = 32'd3125;
   localparam logic [31:0] DivOneBase   = 32'd32768;
   localparam logic [31:0] TempRound    = 32'd128;
   localparam logic [31:0] DividendTop  = 32'h8000_0000;

   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRES_LOW   = 2'd1,
      CSR_PRES_HIGH  = 2'd2,
      CSR_PRES_P9    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] dividend;
      logic [31:0] divisor;
      logic [31:0] remainder;
      logic [31:0] quotient;
      logic [31:0] temperature;
      logic        fault;
      logic        big_dividend;
   } div_stage_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] s;
      s = $signed(x);
      return $unsigned(s >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [32:0]   trial;
      r     = s;
      trial = {s.remainder, s.dividend[31]};
      r.dividend = {s.dividend[30:0], 1'b0};
      if (trial >= {1'b0, s.divisor}) begin
         trial       = trial - {1'b0, s.divisor};
         r.remainder = trial[31:0];
         r.quotient  = {s.quotient[30:0], 1'b1};
      end else begin
         r.remainder = trial[31:0];
         r.quotient  = {s.quotient[30:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ rtl/barometric_pressure_compensation_top.sv @@
// Barometric pressure compensation, 32-bit integer form.
// The req channel carries one item: a raw 20-bit pressure and a raw 20-bit
// temperature reading. The rsp channel returns, per item, the pressure in
// pascals, the temperature in hundredths of a degree and a fault flag that is
// set (with pressure 0) when the pressure divisor is zero.
// Calibration is written through the csr port; the user must write it only while
// no item is in flight, as the block does not enforce this. Index 0 holds
// T1..T3, 1 holds P1..P4, 2 holds P5..P8 and 3 holds P9.
// The pipeline is 46 register stages deep. One item can be accepted every cycle
// while no held result freezes it; most of the depth is the 32-stage restoring
// divider, which retires one quotient bit per stage.
// Valid bits travel with the data. When rsp_stall holds a waiting result, the
// whole pipeline freezes and req_stall is raised; nothing is lost or repeated.
// A synchronous reset empties the pipeline and clears all calibration words.
module barometric_pressure_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_pressure,
   input  logic [19:0] req_raw_temperature,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pressure_pa,
   output logic signed [31:0] rsp_temperature_centi,
   output logic        rsp_divide_fault,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int unsigned FrontStages = 10;

   logic [47:0] temp_cal_ff;
   logic [63:0] pres_low_ff;
   logic [63:0] pres_high_ff;
   logic [15:0] pres_p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= '0;
         pres_low_ff  <= '0;
         pres_high_ff <= '0;
         pres_p9_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::CSR_TEMP_CAL:  temp_cal_ff  <= csr_write_data[47:0];
            bpc_pkg::CSR_PRES_LOW:  pres_low_ff  <= csr_write_data;
            bpc_pkg::CSR_PRES_HIGH: pres_high_ff <= csr_write_data;
            bpc_pkg::CSR_PRES_P9:   pres_p9_ff   <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, temp_cal_ff[15:0]};
   assign t2 = bpc_pkg::sx16(temp_cal_ff[31:16]);
   assign t3 = bpc_pkg::sx16(temp_cal_ff[47:32]);
   assign p1 = {16'd0, pres_low_ff[15:0]};
   assign p2 = bpc_pkg::sx16(pres_low_ff[31:16]);
   assign p3 = bpc_pkg::sx16(pres_low_ff[47:32]);
   assign p4 = bpc_pkg::sx16(pres_low_ff[63:48]);
   assign p5 = bpc_pkg::sx16(pres_high_ff[15:0]);
   assign p6 = bpc_pkg::sx16(pres_high_ff[31:16]);
   assign p7 = bpc_pkg::sx16(pres_high_ff[47:32]);
   assign p8 = bpc_pkg::sx16(pres_high_ff[63:48]);
   assign p9 = bpc_pkg::sx16(pres_p9_ff);

   logic advance;
   logic rsp_valid_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   logic [FrontStages-1:0] front_valid_ff;
   logic [19:0] rp0_ff, rt0_ff, rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff, rp7_ff;
   logic [31:0] m1_ff, dd1_ff, a2_ff, m2_ff, tf3_ff;
   logic [31:0] temp4_ff, pa4_ff, q4_ff;
   logic [31:0] qq5_ff, m5_ff, mp2_5_ff, temp5_ff;
   logic [31:0] b6_ff, mp3_6_ff, m6_ff, mp2_6_ff, temp6_ff;
   logic [31:0] b7_ff, a7_ff, temp7_ff;
   logic [31:0] a8_ff, n8_ff, temp8_ff;
   logic [31:0] pm9_ff, a9_ff, temp9_ff;
   logic [31:0] x1_in, d1_in;

   assign x1_in = {15'd0, rt0_ff[19:3]} - {t1[30:0], 1'b0};
   assign d1_in = {16'd0, rt0_ff[19:4]} - t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (advance) begin
         front_valid_ff <= {front_valid_ff[FrontStages-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rp0_ff   <= req_raw_pressure;
         rt0_ff   <= req_raw_temperature;
         m1_ff    <= bpc_pkg::mul32(x1_in, t2);
         dd1_ff   <= bpc_pkg::mul32(d1_in, d1_in);
         rp1_ff   <= rp0_ff;
         a2_ff    <= bpc_pkg::asr32(m1_ff, 11);
         m2_ff    <= bpc_pkg::mul32(bpc_pkg::asr32(dd1_ff, 12), t3);
         rp2_ff   <= rp1_ff;
         tf3_ff   <= a2_ff + bpc_pkg::asr32(m2_ff, 14);
         rp3_ff   <= rp2_ff;
         temp4_ff <= bpc_pkg::asr32({tf3_ff[29:0], 2'b00} + tf3_ff + bpc_pkg::TempRound, 8);
         pa4_ff   <= bpc_pkg::asr32(tf3_ff, 1) - bpc_pkg::PresOffset;
         q4_ff    <= bpc_pkg::asr32(bpc_pkg::asr32(tf3_ff, 1) - bpc_pkg::PresOffset, 2);
         rp4_ff   <= rp3_ff;
         qq5_ff   <= bpc_pkg::mul32(q4_ff, q4_ff);
         m5_ff    <= bpc_pkg::mul32(pa4_ff, p5);
         mp2_5_ff <= bpc_pkg::mul32(p2, pa4_ff);
         temp5_ff <= temp4_ff;
         rp5_ff   <= rp4_ff;
         b6_ff    <= bpc_pkg::mul32(bpc_pkg::asr32(qq5_ff, 11), p6);
         mp3_6_ff <= bpc_pkg::mul32(p3, bpc_pkg::asr32(qq5_ff, 13));
         m6_ff    <= m5_ff;
         mp2_6_ff <= mp2_5_ff;
         temp6_ff <= temp5_ff;
         rp6_ff   <= rp5_ff;
         b7_ff    <= bpc_pkg::asr32(b6_ff + {m6_ff[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
         a7_ff    <= bpc_pkg::asr32(bpc_pkg::asr32(mp3_6_ff, 3)
                                    + bpc_pkg::asr32(mp2_6_ff, 1), 18);
         temp7_ff <= temp6_ff;
         rp7_ff   <= rp6_ff;
         a8_ff    <= bpc_pkg::asr32(bpc_pkg::mul32(bpc_pkg::DivOneBase + a7_ff, p1), 15);
         n8_ff    <= (bpc_pkg::PresFullSc - {12'd0, rp7_ff}) - bpc_pkg::asr32(b7_ff, 12);
         temp8_ff <= temp7_ff;
         pm9_ff   <= bpc_pkg::mul32(n8_ff, bpc_pkg::PresScale);
         a9_ff    <= a8_ff;
         temp9_ff <= temp8_ff;
      end
   end

   // The divider: one restoring step per stage, most significant bit first.
   bpc_pkg::div_stage_type div_ff [0:bpc_pkg::DivSteps];
   logic [bpc_pkg::DivSteps:0] div_valid_ff;
   bpc_pkg::div_stage_type div_entry_in;

   always_comb begin
      div_entry_in.big_dividend = (pm9_ff >= bpc_pkg::DividendTop);
      div_entry_in.dividend     = div_entry_in.big_dividend ? pm9_ff : {pm9_ff[30:0], 1'b0};
      div_entry_in.divisor      = a9_ff;
      div_entry_in.remainder    = '0;
      div_entry_in.quotient     = '0;
      div_entry_in.temperature  = temp9_ff;
      div_entry_in.fault        = (a9_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else if (advance) begin
         div_valid_ff <= {div_valid_ff[bpc_pkg::DivSteps-1:0], front_valid_ff[FrontStages-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div_entry_in;
         for (int k = 0; k < bpc_pkg::DivSteps; k++) begin
            div_ff[k+1] <= bpc_pkg::div_step(div_ff[k]);
         end
      end
   end

   logic [31:0] quot_in;
   logic        post1_valid_ff, post2_valid_ff;
   logic [31:0] pq1_ff, x1_ff, m81_ff, temp_p1_ff;
   logic [31:0] pq2_ff, a2p_ff, b2p_ff, temp_p2_ff;
   logic        fault1_ff, fault2_ff;
   logic [31:0] pres_out_ff, temp_out_ff;
   logic        fault_out_ff;

   assign quot_in = div_ff[bpc_pkg::DivSteps].big_dividend
                    ? {div_ff[bpc_pkg::DivSteps].quotient[30:0], 1'b0}
                    : div_ff[bpc_pkg::DivSteps].quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         post1_valid_ff <= 1'b0;
         post2_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         post1_valid_ff <= div_valid_ff[bpc_pkg::DivSteps];
         post2_valid_ff <= post1_valid_ff;
         rsp_valid_ff   <= post2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pq1_ff       <= quot_in;
         x1_ff        <= bpc_pkg::mul32({3'd0, quot_in[31:3]}, {3'd0, quot_in[31:3]});
         m81_ff       <= bpc_pkg::mul32({2'd0, quot_in[31:2]}, p8);
         temp_p1_ff   <= div_ff[bpc_pkg::DivSteps].temperature;
         fault1_ff    <= div_ff[bpc_pkg::DivSteps].fault;
         pq2_ff       <= pq1_ff;
         a2p_ff       <= bpc_pkg::asr32(bpc_pkg::mul32(p9, {13'd0, x1_ff[31:13]}), 12);
         b2p_ff       <= bpc_pkg::asr32(m81_ff, 13);
         temp_p2_ff   <= temp_p1_ff;
         fault2_ff    <= fault1_ff;
         pres_out_ff  <= fault2_ff ? '0 : pq2_ff + bpc_pkg::asr32(a2p_ff + b2p_ff + p7, 4);
         temp_out_ff  <= temp_p2_ff;
         fault_out_ff <= fault2_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pressure_pa       = pres_out_ff;
   assign rsp_temperature_centi = $signed(temp_out_ff);
   assign rsp_divide_fault      = fault_out_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_pressure_pa == '0)
      else $error("Faulted item carries a nonzero pressure.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && div_valid_ff == '0)
      else $error("Pipeline not empty after reset.");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(div_valid_ff) && $stable(front_valid_ff))
      else $error("Pipeline moved while the result was held.");

endmodule
